// ===== rtl/core/sfs_pkg.sv =====
// Package for the slot allocator free stack core.
// Holds the field widths, the mode and status codes, the beat payload types
// and the controller/datapath command and status structs. No dependencies.
package sfs_pkg;

    localparam int MAX_SLOTS_DEFAULT = 64;
    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXPIRE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALIVE = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot_index;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        logic                granted;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic scan;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_search;
        logic out_busy;
        logic scan_done;
    } dp_status_t;

endpackage

// ===== rtl/core/sfs_stream_if.sv =====
// Valid/ready stream interface used for the input and result channels.
// Payload type is a parameter; typically sfs_pkg::in_item_t or out_item_t.
interface sfs_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ===== rtl/core/sfs_ctrl.sv =====
// Controller state machine for the slot allocator free stack core.
// Sequences accept, execute and free-slot scan; depends on sfs_pkg.
module sfs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sfs_pkg::dp_status_t stat,
    output sfs_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold while the previous result is still waiting
                if (!stat.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.need_search ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/sfs_datapath.sv =====
// Datapath for the slot allocator free stack core: alive map, free stack
// memory, high-water and depth counters, scan counter and result register.
// Depends on sfs_pkg and sfs_stream_if.
module sfs_datapath #(
    parameter int MAX_SLOTS = sfs_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sfs_pkg::in_item_t   in_item,
    input  sfs_pkg::ctrl_cmd_t  cmd,
    output sfs_pkg::dp_status_t stat,
    sfs_stream_if.source        out_ch
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int DW = $clog2(MAX_SLOTS + 1);

    logic [sfs_pkg::MODE_W-1:0] mode_reg;
    logic [sfs_pkg::SLOT_W-1:0] slot_reg;
    logic [sfs_pkg::SLOT_W-1:0] rd_reg;

    logic [MAX_SLOTS-1:0] alive_reg;
    logic [MAX_SLOTS-1:0] alive_next;
    logic [DW-1:0]        depth_reg;
    logic [DW-1:0]        depth_next;
    logic [DW-1:0]        hw_reg;
    logic [DW-1:0]        hw_next;
    logic [AW-1:0]        scan_reg;
    logic [AW-1:0]        scan_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    sfs_pkg::out_item_t   out_data_reg;
    sfs_pkg::out_item_t   out_data_next;

    logic [sfs_pkg::SLOT_W-1:0] stack_mem [MAX_SLOTS];
    logic                       mem_we;

    logic [AW-1:0] slot_addr;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] alloc_pick;
    logic          slot_alive;
    logic          scan_last;

    assign slot_addr  = AW'(slot_reg);
    assign top_addr   = AW'(depth_reg - DW'(1));
    assign slot_alive = (32'(slot_reg) < 32'(MAX_SLOTS)) && alive_reg[slot_addr];
    assign alloc_pick = (depth_reg != '0) ? AW'(rd_reg) : AW'(hw_reg);
    assign scan_last  = (scan_reg == AW'(MAX_SLOTS - 1));

    assign stat.need_search = (mode_reg == sfs_pkg::MODE_ALLOC) && (depth_reg == '0)
                              && (hw_reg == DW'(MAX_SLOTS));
    assign stat.out_busy    = out_valid_reg && !out_ch.ready;
    assign stat.scan_done   = !alive_reg[scan_reg] || scan_last;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_data_reg;

    always_comb
    begin
        alive_next     = alive_reg;
        depth_next     = depth_reg;
        hw_next        = hw_reg;
        scan_next      = scan_reg;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;

        if (cmd.exec && stat.need_search)
        begin
            scan_next = '0;
        end
        else if (cmd.exec)
        begin
            out_valid_next             = 1'b1;
            out_data_next.granted_slot = '0;
            out_data_next.granted      = 1'b0;
            out_data_next.status       = sfs_pkg::ST_OK;
            case (mode_reg) inside
                sfs_pkg::MODE_ALLOC:
                begin
                    if (depth_reg != '0)
                    begin
                        depth_next = depth_reg - DW'(1);
                    end
                    else
                    begin
                        hw_next = hw_reg + DW'(1);
                    end
                    alive_next[alloc_pick]     = 1'b1;
                    out_data_next.granted_slot = sfs_pkg::SLOT_W'(alloc_pick);
                    out_data_next.granted      = 1'b1;
                end
                sfs_pkg::MODE_RELEASE, sfs_pkg::MODE_EXPIRE:
                begin
                    if (!slot_alive)
                    begin
                        out_data_next.status = sfs_pkg::ST_NOT_ALIVE;
                    end
                    else
                    begin
                        alive_next[slot_addr] = 1'b0;
                        if ((mode_reg == sfs_pkg::MODE_RELEASE)
                            && (depth_reg != DW'(MAX_SLOTS)))
                        begin
                            mem_we     = 1'b1;
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                end
                default:
                begin
                    alive_next = '0;
                    depth_next = '0;
                    hw_next    = '0;
                end
            endcase
        end

        if (cmd.scan)
        begin
            if (!alive_reg[scan_reg])
            begin
                alive_next[scan_reg]       = 1'b1;
                out_valid_next             = 1'b1;
                out_data_next.granted_slot = sfs_pkg::SLOT_W'(scan_reg);
                out_data_next.granted      = 1'b1;
                out_data_next.status       = sfs_pkg::ST_OK;
            end
            else if (scan_last)
            begin
                out_valid_next             = 1'b1;
                out_data_next.granted_slot = '0;
                out_data_next.granted      = 1'b0;
                out_data_next.status       = sfs_pkg::ST_FULL;
            end
            else
            begin
                scan_next = scan_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg     <= '0;
            depth_reg     <= '0;
            hw_reg        <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            alive_reg     <= alive_next;
            depth_reg     <= depth_next;
            hw_reg        <= hw_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (cmd.latch)
        begin
            mode_reg <= in_item.mode;
            slot_reg <= in_item.slot_index;
        end
    end

    // free stack: one write port, one registered read of the top entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[depth_reg[AW-1:0]] <= slot_reg;
        end
        if (cmd.latch)
        begin
            rd_reg <= stack_mem[top_addr];
        end
    end

endmodule

// ===== rtl/core/slot_allocator_free_stack_core.sv =====
// Top level of the slot allocator free stack core.
// Joins sfs_ctrl and sfs_datapath; depends on sfs_pkg and sfs_stream_if.
//
//   channel  dir  modport  payload              beat
//   in_ch    in   sink     mode, slot_index     request
//   out_ch   out  source   granted_slot,        one result per request
//                          granted, status
//
// Sequence: accept, then execute, per request; an allocate with an empty stack
//   and the high-water mark at MAX_SLOTS adds a scan of the alive map, one
//   alive bit per cycle.
// Reset: rst_n clears the alive map, counters, state and result valid;
//   free stack memory contents are not reset.
// Stalls: the result register holds a waiting beat while the next request
//   is accepted; execution waits until that result is taken.
module slot_allocator_free_stack_core #(
    parameter int MAX_SLOTS = sfs_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    sfs_stream_if.sink   in_ch,
    sfs_stream_if.source out_ch
);

    sfs_pkg::ctrl_cmd_t  cmd;
    sfs_pkg::dp_status_t stat;
    sfs_pkg::in_item_t   in_item;
    logic                ctrl_ready;
    logic                in_fire;

    assign in_ch.ready = ctrl_ready;
    assign in_item     = in_ch.payload;
    assign in_fire     = in_ch.valid && ctrl_ready;

    sfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ctrl_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfs_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .cmd     (cmd),
        .stat    (stat),
        .out_ch  (out_ch)
    );

`ifndef ASSERT_OFF
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({in_fire, cmd.exec, cmd.scan}))
        else $error("accept, execute and scan overlap");

    a_exec_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !stat.out_busy)
        else $error("execute while result register is occupied");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !ctrl_ready)
        else $error("request accepted during execution");

    a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> !stat.out_busy)
        else $error("scan result would overwrite a waiting beat");
`endif

endmodule
